[rtl/cscl_pkg.sv]
// shared constants and types for the line clipper
// outcode bits, register indexes and the divider status bundle
// no dependencies
`timescale 1ns / 1ps

package cscl_pkg;

  // outcode bits
  localparam logic [3:0] CODE_LEFT   = 4'd1;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_TOP    = 4'd8;

  // clip step counter
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] MAX_CLIPS = 3'd4;

  // configuration register map
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RIGHT  = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP    = 8'd3;

  // status of the shared multiply-divide unit
  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

[rtl/cscl_muldiv.sv]
// shared multiply then bit-serial divide unit: |a*b| / |d| with result sign
// a multiply step, then one quotient bit per cycle (restoring)
// depends on cscl_pkg
`timescale 1ns / 1ps

module cscl_muldiv #(
  parameter int unsigned DW = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [DW-1:0]   op_a,
  input  logic signed [DW-1:0]   op_b,
  input  logic signed [DW-1:0]   op_d,
  output cscl_pkg::md_stat_t     stat,
  output logic [2*DW-1:0]        quot,
  output logic                   neg
);
  import cscl_pkg::*;

  localparam int unsigned PW = 2 * DW;
  localparam int unsigned CW = $clog2(PW);
  localparam int unsigned RW = DW + 1;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  md_state_t       state_r, state_nxt;
  logic            done_r, done_nxt;
  logic            neg_r, neg_nxt;
  logic [DW-1:0]   ma_r, ma_nxt;
  logic [DW-1:0]   mb_r, mb_nxt;
  logic [DW-1:0]   md_r, md_nxt;
  logic [PW-1:0]   quo_r, quo_nxt;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [RW-1:0]   rem_sh;
  logic            q_bit;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    md_nxt    = md_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    rem_sh    = {rem_r[RW-2:0], quo_r[PW-1]};
    q_bit     = rem_sh >= {1'b0, md_r};
    case (state_r)
      MD_IDLE: begin
        if (start) begin
          ma_nxt    = mag(op_a);
          mb_nxt    = mag(op_b);
          md_nxt    = mag(op_d);
          neg_nxt   = op_a[DW-1] ^ op_b[DW-1] ^ op_d[DW-1];
          state_nxt = MD_MUL;
        end
      end
      MD_MUL: begin
        quo_nxt   = PW'(ma_r) * PW'(mb_r);
        rem_nxt   = '0;
        cnt_nxt   = CW'(PW - 1);
        state_nxt = MD_DIV;
      end
      MD_DIV: begin
        rem_nxt = q_bit ? RW'(rem_sh - {1'b0, md_r}) : rem_sh;
        quo_nxt = {quo_r[PW-2:0], q_bit};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = MD_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    neg_r <= neg_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    md_r  <= md_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = (state_r != MD_IDLE);
  assign stat.done = done_r;
  assign quot      = quo_r;
  assign neg       = neg_r;

endmodule

[rtl/cohen_sutherland_line_clipper.sv]
// each request runs k clip steps, k = 0..4; one request in flight at a time
// each clip step is a multiply then the bit-serial divider, one quotient bit per cycle
// a new request is taken the cycle after the result enters the output register
// reset (rst_n low, synchronous): window back to -150/150/-100/100, sequencer idle, no result
`timescale 1ns / 1ps

module cohen_sutherland_line_clipper #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request: start_x, start_y, end_x, end_y (lowest bits first), zero padded
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  // result: clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0]   out_tdata,
  // result flag: accepted
  output logic                                 out_tuser,
  // window register writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cscl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data
);
  import cscl_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;        // coordinate differences
  localparam int unsigned PW = 2 * DW;       // full product / quotient
  localparam int unsigned SW = PW + 2;       // base plus signed quotient
  localparam int unsigned TW = ((4 * W + 7) / 8) * 8;

  // saturation limits for the intersection coordinate
  localparam logic signed [SW-1:0] C_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] C_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_WAIT, S_FINISH} state_t;

  // window registers
  logic signed [W-1:0] win_left_r, win_right_r, win_bottom_r, win_top_r;

  // sequencer and working endpoints
  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 acc_r, acc_nxt;
  logic signed [W-1:0]  x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic signed [W-1:0]  edge_r, edge_nxt, base_r, base_nxt;
  logic                 vert_r, vert_nxt;
  logic                 first_r, first_nxt;

  // output register
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_acc_r, out_acc_nxt;
  logic [4*W-1:0]       out_xy_r, out_xy_nxt;

  // decide-step logic
  logic [3:0]           c1, c2, co;
  logic                 co_first, co_vert;
  logic signed [W-1:0]  clip_edge;
  logic signed [DW-1:0] dx, dy, op_a, op_b, op_d;

  // intersection update
  logic signed [SW-1:0] q_signed, isect_sum;
  logic signed [W-1:0]  isect, new_x, new_y;

  // shared multiply-divide unit
  logic                 md_start;
  md_stat_t             md_stat;
  logic [PW-1:0]        md_quot;
  logic                 md_neg;

  function automatic logic [3:0] outcode(
    input logic signed [W-1:0] x,
    input logic signed [W-1:0] y,
    input logic signed [W-1:0] wl,
    input logic signed [W-1:0] wr,
    input logic signed [W-1:0] wb,
    input logic signed [W-1:0] wt
  );
    logic [3:0] c;
    c = 4'd0;
    if (x < wl) c = c | CODE_LEFT;
    else if (x > wr) c = c | CODE_RIGHT;
    if (y < wb) c = c | CODE_BOTTOM;
    else if (y > wt) c = c | CODE_TOP;
    return c;
  endfunction

  // configuration: always ready, indexes beyond the map are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= W'(-150);
      win_right_r  <= W'(150);
      win_bottom_r <= W'(-100);
      win_top_r    <= W'(100);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LEFT:   win_left_r   <= cfg_data;
        REG_WINDOW_RIGHT:  win_right_r  <= cfg_data;
        REG_WINDOW_BOTTOM: win_bottom_r <= cfg_data;
        REG_WINDOW_TOP:    win_top_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // outcodes of the current endpoints and the operands of the next clip
  always_comb begin
    c1 = outcode(x1_r, y1_r, win_left_r, win_right_r, win_bottom_r, win_top_r);
    c2 = outcode(x2_r, y2_r, win_left_r, win_right_r, win_bottom_r, win_top_r);
    co_first = (c1 != 4'd0);
    co       = co_first ? c1 : c2;
    // top/bottom crossing takes priority over right/left
    co_vert  = ((co & (CODE_TOP | CODE_BOTTOM)) != 4'd0);
    if (co_vert)
      clip_edge = ((co & CODE_TOP) != 4'd0) ? win_top_r : win_bottom_r;
    else
      clip_edge = ((co & CODE_RIGHT) != 4'd0) ? win_right_r : win_left_r;
    dx   = DW'(x2_r) - DW'(x1_r);
    dy   = DW'(y2_r) - DW'(y1_r);
    op_a = co_vert ? dx : dy;
    op_d = co_vert ? dy : dx;
    op_b = co_vert ? (DW'(clip_edge) - DW'(y1_r)) : (DW'(clip_edge) - DW'(x1_r));
  end

  // intersection: base + sign * quotient, saturated to the coordinate range
  always_comb begin
    q_signed  = md_neg ? -SW'({2'b00, md_quot}) : SW'({2'b00, md_quot});
    isect_sum = SW'(base_r) + q_signed;
    if (isect_sum > C_MAX)      isect = C_MAX[W-1:0];
    else if (isect_sum < C_MIN) isect = C_MIN[W-1:0];
    else                        isect = isect_sum[W-1:0];
    new_x = vert_r ? isect : edge_r;
    new_y = vert_r ? edge_r : isect;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    acc_nxt        = acc_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    x2_nxt         = x2_r;
    y2_nxt         = y2_r;
    edge_nxt       = edge_r;
    base_nxt       = base_r;
    vert_nxt       = vert_r;
    first_nxt      = first_r;
    out_acc_nxt    = out_acc_r;
    out_xy_nxt     = out_xy_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    md_start       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          x1_nxt    = in_tdata[W-1:0];
          y1_nxt    = in_tdata[2*W-1:W];
          x2_nxt    = in_tdata[3*W-1:2*W];
          y2_nxt    = in_tdata[4*W-1:3*W];
          step_nxt  = '0;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (c1 == 4'd0 && c2 == 4'd0) begin
          // both endpoints inside
          acc_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else if ((c1 & c2) != 4'd0 || step_r == MAX_CLIPS || op_d == '0) begin
          // trivially outside, out of clip steps, or a degenerate crossing
          acc_nxt   = 1'b0;
          state_nxt = S_FINISH;
        end else begin
          md_start  = 1'b1;
          edge_nxt  = clip_edge;
          base_nxt  = co_vert ? x1_r : y1_r;
          vert_nxt  = co_vert;
          first_nxt = co_first;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (md_stat.done) begin
          if (first_r) begin
            x1_nxt = new_x;
            y1_nxt = new_y;
          end else begin
            x2_nxt = new_x;
            y2_nxt = new_y;
          end
          step_nxt  = step_r + 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_FINISH: begin
        // wait for the output register to drain
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_acc_nxt    = acc_r;
          out_xy_nxt     = acc_r ? {y2_r, x2_r, y1_r, x1_r} : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      step_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      step_r       <= step_nxt;
    end
    acc_r     <= acc_nxt;
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    x2_r      <= x2_nxt;
    y2_r      <= y2_nxt;
    edge_r    <= edge_nxt;
    base_r    <= base_nxt;
    vert_r    <= vert_nxt;
    first_r   <= first_nxt;
    out_acc_r <= out_acc_nxt;
    out_xy_r  <= out_xy_nxt;
  end

  cscl_muldiv #(
    .DW (DW)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .op_a  (op_a),
    .op_b  (op_b),
    .op_d  (op_d),
    .stat  (md_stat),
    .quot  (md_quot),
    .neg   (md_neg)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_acc_r;
  assign out_tdata  = TW'(out_xy_r);

  // a rejected segment carries all-zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("rejected result with nonzero coordinates");

  // a clip step always gets the divider going
  a_md_start: assert property (@(posedge clk) disable iff (!rst_n)
    md_start |=> md_stat.busy)
    else $error("divider did not start");

  // no new request while the divider still works on the last one
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !md_stat.busy)
    else $error("ready while divider busy");

  // clip step count is bounded by the guard
  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= MAX_CLIPS)
    else $error("clip step count beyond guard");

endmodule
